// ===== hw/rtl/cti_pkg.sv =====
`timescale 1ns / 1ps
package cti_pkg;
	localparam int TableDepth = 16;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic signed [31:0] x_value;
		logic signed [31:0] y_value;
	} cti_in_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [1:0] status;
		logic [4:0] entry_count;
	} cti_out_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH, S_SRCH_RD, S_DECIDE, S_SHIFT, S_WRITE,
		S_QRD0, S_QRD1, S_MUL, S_DIV, S_DONE
	} cti_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic srch_init;
		logic srch_step;
		logic rd_pos;
		logic rd_pos_m1;
		logic cap_lo;
		logic cap_hi;
		logic shift_step;
		logic write_new;
		logic write_y;
		logic clear;
		logic mul;
		logic div_init;
		logic div_step;
		logic fin_zero;
		logic fin_y;
		logic fin_interp;
		logic [1:0] status;
	} cti_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic srch_done;
		logic full;
		logic empty;
		logic hit;
		logic below_first;
		logic above_last;
		logic shift_done;
		logic div_done;
	} cti_stat_t;
endpackage

// ===== hw/rtl/calibration_table_interpolator.sv =====
`timescale 1ns / 1ps
// clear and unused mode go straight to done; insert and query search the table first
// the restoring divider sets the query time; insert time is set by search and shift
// one item at a time; start is taken only while busy is low
// result shows for one cycle with done; the receiver cannot stall
// arst_n empties the table and returns the controller to idle
module calibration_table_interpolator (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cti_pkg::cti_in_t in_word,
	output logic busy,
	output logic done,
	output cti_pkg::cti_out_t out_word
);
	import cti_pkg::*;

	cti_cmd_t cmd;
	cti_stat_t stat;

	cti_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .mode(in_word.mode),
		.stat(stat), .cmd(cmd), .busy(busy), .done(done)
	);

	cti_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .in_word(in_word), .cmd(cmd), .done(done),
		.stat(stat), .out_word(out_word)
	);
endmodule

// ===== hw/rtl/cti_ctrl.sv =====
`timescale 1ns / 1ps
module cti_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] mode,
	input  cti_pkg::cti_stat_t stat,
	output cti_pkg::cti_cmd_t cmd,
	output logic busy,
	output logic done
);
	import cti_pkg::*;

	cti_state_t state_q, state_d;
	logic [1:0] mode_q;
	logic full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= MODE_CLEAR;
			full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// table full as seen when the word arrived
			if (start && state_q == S_IDLE) begin
				mode_q <= mode;
				full_q <= stat.full;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) begin
				if (mode inside {MODE_INSERT, MODE_QUERY}) state_d = S_SRCH;
				else state_d = S_DONE;
			end
			S_SRCH: begin
				if (mode_q == MODE_INSERT && stat.full) state_d = S_DONE;
				else if (mode_q == MODE_QUERY && stat.empty) state_d = S_DONE;
				else if (stat.srch_done) state_d = S_SRCH_RD;
				else state_d = S_SRCH;
			end
			S_SRCH_RD: state_d = S_DECIDE;
			S_DECIDE: begin
				if (mode_q == MODE_INSERT) state_d = stat.hit ? S_DONE : S_SHIFT;
				else if (stat.below_first || stat.above_last || stat.hit) state_d = S_DONE;
				else state_d = S_QRD0;
			end
			S_SHIFT: state_d = stat.shift_done ? S_WRITE : S_SHIFT;
			S_WRITE: state_d = S_DONE;
			S_QRD0: state_d = S_QRD1;
			S_QRD1: state_d = S_MUL;
			S_MUL: state_d = S_DIV;
			S_DIV: state_d = stat.div_done ? S_DONE : S_DIV;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != S_IDLE);
		done = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
				cmd.srch_init = start;
				cmd.clear = start && mode == MODE_CLEAR;
			end
			S_SRCH: cmd.srch_step = 1'b1;
			S_SRCH_RD: cmd.rd_pos = 1'b1;
			S_DECIDE: begin
				cmd.write_y = (mode_q == MODE_INSERT) && stat.hit;
				cmd.fin_y = (mode_q == MODE_QUERY);
				cmd.cap_hi = 1'b1;
			end
			S_SHIFT: cmd.shift_step = 1'b1;
			S_WRITE: cmd.write_new = 1'b1;
			S_QRD0: cmd.rd_pos_m1 = 1'b1;
			S_QRD1: cmd.cap_lo = 1'b1;
			S_MUL: begin
				cmd.mul = 1'b1;
				cmd.div_init = 1'b1;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cmd.fin_interp = stat.div_done;
			end
			S_DONE: begin
				done = 1'b1;
				if (mode_q == MODE_INSERT && full_q) cmd.status = ST_FULL;
				if (mode_q == MODE_QUERY && stat.empty) cmd.status = ST_EMPTY;
				cmd.fin_zero = (mode_q != MODE_QUERY) || stat.empty;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.write_new, cmd.write_y, cmd.shift_step}) <= 1)
		else $error("conflicting table writes");
`endif
endmodule

// ===== hw/rtl/cti_dpath.sv =====
`timescale 1ns / 1ps
module cti_dpath (
	input  logic clk,
	input  logic arst_n,
	input  cti_pkg::cti_in_t in_word,
	input  cti_pkg::cti_cmd_t cmd,
	input  logic done,
	output cti_pkg::cti_stat_t stat,
	output cti_pkg::cti_out_t out_word
);
	import cti_pkg::*;

	localparam int PosW = $clog2(TableDepth + 1);

	logic [31:0] mem_x [TableDepth];
	logic [31:0] mem_y [TableDepth];
	logic [31:0] rx_q, ry_q;
	logic [IdxW-1:0] raddr;
	logic rd_en;

	logic [31:0] key_q, ykey_q;
	logic [CntW-1:0] count_q;
	logic [PosW-1:0] lo_q, hi_q, sh_q;
	logic [31:0] x1_q, y1_q, x0_q, y0_q;
	logic [63:0] prod_q;
	logic [31:0] span_q;
	logic [32:0] rem_q;
	logic [6:0] dcnt_q;
	logic neg_q;
	logic [31:0] res_q;
	logic srch_wait_q;

	logic [PosW-1:0] mid;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// one read port: address chosen by command
	always_comb begin
		rd_en = 1'b1;
		raddr = mid[IdxW-1:0];
		if (cmd.rd_pos) begin
			// past the end: read the last point instead
			if (lo_q >= PosW'(count_q)) raddr = IdxW'(count_q - 1'b1);
			else raddr = lo_q[IdxW-1:0];
		end else if (cmd.cap_hi) raddr = IdxW'(count_q - 1'b1);
		else if (cmd.rd_pos_m1) raddr = IdxW'(lo_q - 1'b1);
		// shift reads one entry ahead of the write
		else if (cmd.shift_step) raddr = IdxW'(sh_q - 2'd2);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rx_q <= mem_x[raddr];
			ry_q <= mem_y[raddr];
		end
		if (cmd.shift_step && sh_q > lo_q) begin
			mem_x[sh_q[IdxW-1:0]] <= rx_q;
			mem_y[sh_q[IdxW-1:0]] <= ry_q;
		end
		if (cmd.write_new) begin
			mem_x[lo_q[IdxW-1:0]] <= key_q;
			mem_y[lo_q[IdxW-1:0]] <= ykey_q;
		end
		if (cmd.write_y) mem_y[lo_q[IdxW-1:0]] <= ykey_q;
	end

	// search: each probe issues a read, then compares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			srch_wait_q <= 1'b0;
		end else begin
			if (cmd.clear) count_q <= '0;
			else if (cmd.write_new) count_q <= count_q + 1'b1;
			if (cmd.srch_init) srch_wait_q <= 1'b0;
			else if (cmd.srch_step) srch_wait_q <= !srch_wait_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= in_word.x_value ^ 32'h8000_0000;
			ykey_q <= in_word.y_value ^ 32'h8000_0000;
			lo_q <= '0;
			hi_q <= PosW'(count_q);
		end else if (cmd.srch_step && srch_wait_q && lo_q < hi_q) begin
			if (rx_q < key_q) lo_q <= mid + 1'b1;
			else hi_q <= mid;
		end
		if (cmd.cap_hi) begin
			x1_q <= rx_q;
			y1_q <= ry_q;
			sh_q <= PosW'(count_q);
		end else if (cmd.shift_step && sh_q > lo_q) sh_q <= sh_q - 1'b1;
		if (cmd.cap_lo) begin
			x0_q <= rx_q;
			y0_q <= ry_q;
		end
		if (cmd.mul) begin
			prod_q <= 64'(key_q - x0_q) * 64'((y1_q < y0_q) ? (y0_q - y1_q) : (y1_q - y0_q));
			neg_q <= y1_q < y0_q;
			span_q <= x1_q - x0_q;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step && !dcnt_q[6]) begin
			// restoring division, one quotient bit per cycle
			if ({rem_q[31:0], prod_q[63]} >= {1'b0, span_q}) begin
				rem_q <= {rem_q[31:0], prod_q[63]} - {1'b0, span_q};
				prod_q <= {prod_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], prod_q[63]};
				prod_q <= {prod_q[62:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.fin_y) res_q <= ry_q;
		if (cmd.fin_interp) res_q <= neg_q ? (y0_q - prod_q[31:0]) : (y0_q + prod_q[31:0]);
	end

	// search over when lo meets hi
	assign stat.srch_done = (lo_q >= hi_q);
	assign stat.full = (count_q >= CntW'(TableDepth));
	assign stat.empty = (count_q == '0);
	assign stat.hit = (lo_q < PosW'(count_q)) && (rx_q == key_q);
	assign stat.below_first = (lo_q == '0);
	assign stat.above_last = (lo_q >= PosW'(count_q));
	assign stat.shift_done = (sh_q <= lo_q);
	assign stat.div_done = dcnt_q[6];

	// result word, valid while done is high
	always_comb begin
		out_word.result_value = (cmd.fin_zero) ? 32'sd0 : $signed(res_q ^ 32'h8000_0000);
		out_word.status = cmd.status;
		out_word.entry_count = 5'(count_q);
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(TableDepth)) else $error("count overflow");
	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srch_step |-> (lo_q <= hi_q && hi_q <= PosW'(TableDepth)))
		else $error("search out of range");
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cmd.fin_zero) |-> out_word.result_value == 0) else $error("nonzero result");
`endif
endmodule
